### design/kcl_pkg.sv
package kcl_pkg;

	localparam int CODE_SLOTS    = 6;
	localparam int NEW_CODE_KEYS = 4;
	localparam int SAVE_KEYS     = (NEW_CODE_KEYS < CODE_SLOTS) ? NEW_CODE_KEYS : CODE_SLOTS - 1;

	localparam int POS_W      = $clog2(CODE_SLOTS + 1);
	localparam int SLOT_IDX_W = $clog2(CODE_SLOTS);
	localparam int CPOS_W     = $clog2(NEW_CODE_KEYS + 1);
	localparam int PEND_IDX_W = (NEW_CODE_KEYS > 1) ? $clog2(NEW_CODE_KEYS) : 1;
	localparam int WIN_W      = 4;

	localparam logic [7:0] KEY_NONE       = 8'h00;
	localparam logic [7:0] KEY_HASH       = 8'h23;
	localparam logic [7:0] KEY_STAR       = 8'h2A;
	localparam logic [7:0] KEY_DIGIT_ZERO = 8'h30;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd10;
	localparam logic [WIN_W-1:0] WINDOW_MAX   = 4'd15;

	typedef enum logic [1:0] {
		Q_IDLE,
		Q_PRESSED,
		Q_WAIT
	} qual_state_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_START,
		L_WAIT,
		L_PRESSED,
		L_OPEN
	} lock_state_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_START,
		C_WAIT_PRESS,
		C_WAIT_RELEASE,
		C_REENTER,
		C_REL_AGAIN,
		C_SAVE
	} change_state_t;

	typedef logic [CODE_SLOTS-1:0][7:0] code_store_t;

	// stored code as seen by the lock
	typedef struct packed {
		code_store_t       store;
		logic [POS_W-1:0]  length;
	} code_t;

	// '#' followed by '1', '2', ...
	function automatic code_store_t code_store_reset();
		code_store_t s;
		s[0] = KEY_HASH;
		for (int k = 1; k < CODE_SLOTS; k++) begin
			s[k] = KEY_DIGIT_ZERO + 8'(k);
		end
		return s;
	endfunction

endpackage

### design/kcl_qual.sv
module kcl_qual (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] key_code,
	output logic [7:0] held_key_next
);

	kcl_pkg::qual_state_t state_q, state_d;
	logic [7:0]           held_key_q;

	always_comb begin
		unique case (state_q)
			kcl_pkg::Q_IDLE: begin
				state_d = (key_code != kcl_pkg::KEY_NONE) ? kcl_pkg::Q_PRESSED : kcl_pkg::Q_IDLE;
			end
			kcl_pkg::Q_PRESSED: begin
				if (key_code == kcl_pkg::KEY_NONE) begin
					state_d = kcl_pkg::Q_IDLE;
				end else if (held_key_q == key_code) begin
					state_d = kcl_pkg::Q_PRESSED;
				end else begin
					// another key cut in: drop it and wait for release
					state_d = kcl_pkg::Q_WAIT;
				end
			end
			kcl_pkg::Q_WAIT: begin
				state_d = (key_code != kcl_pkg::KEY_NONE) ? kcl_pkg::Q_WAIT : kcl_pkg::Q_IDLE;
			end
			default: begin
				state_d = kcl_pkg::Q_IDLE;
			end
		endcase
		held_key_next = (state_d == kcl_pkg::Q_PRESSED) ? key_code : kcl_pkg::KEY_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kcl_pkg::Q_IDLE;
			held_key_q <= kcl_pkg::KEY_NONE;
		end else if (step) begin
			state_q    <= state_d;
			held_key_q <= held_key_next;
		end
	end

endmodule

### design/kcl_lock.sv
module kcl_lock (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     held_key,
	input  logic           lock_button,
	input  kcl_pkg::code_t code,
	output logic           unlocked_next
);

	kcl_pkg::lock_state_t        state_q, state_d;
	logic [kcl_pkg::POS_W-1:0]   pos_q, pos_d;
	logic                        flag_q, flag_d;
	logic [kcl_pkg::POS_W-1:0]   rd_addr;
	logic [7:0]                  stored;

	// one compare per state: slot 0, current slot or the slot just matched
	always_comb begin
		unique case (state_q)
			kcl_pkg::L_WAIT:    rd_addr = pos_q;
			kcl_pkg::L_PRESSED: rd_addr = pos_q - kcl_pkg::POS_W'(1);
			default:            rd_addr = '0;
		endcase
		if (rd_addr < kcl_pkg::POS_W'(kcl_pkg::CODE_SLOTS)) begin
			stored = code.store[rd_addr[kcl_pkg::SLOT_IDX_W-1:0]];
		end else begin
			stored = kcl_pkg::KEY_NONE;
		end
	end

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		flag_d  = flag_q;
		unique case (state_q)
			kcl_pkg::L_IDLE: begin
				pos_d = '0;
				if (held_key == stored) begin
					state_d = kcl_pkg::L_START;
					pos_d   = kcl_pkg::POS_W'(1);
				end
			end
			kcl_pkg::L_START: begin
				if (held_key == stored) begin
					state_d = kcl_pkg::L_START;
				end else if (held_key == kcl_pkg::KEY_NONE) begin
					state_d = kcl_pkg::L_WAIT;
				end else begin
					state_d = kcl_pkg::L_IDLE;
				end
			end
			kcl_pkg::L_WAIT: begin
				if (held_key == stored) begin
					state_d = kcl_pkg::L_PRESSED;
					pos_d   = pos_q + kcl_pkg::POS_W'(1);
				end else if (held_key != kcl_pkg::KEY_NONE) begin
					state_d = kcl_pkg::L_IDLE;
				end
			end
			kcl_pkg::L_PRESSED: begin
				if (held_key == kcl_pkg::KEY_NONE && pos_q >= code.length) begin
					state_d = kcl_pkg::L_OPEN;
				end else if (held_key == kcl_pkg::KEY_NONE) begin
					state_d = kcl_pkg::L_WAIT;
				end else if (pos_q == '0 || held_key != stored) begin
					state_d = kcl_pkg::L_IDLE;
				end
			end
			kcl_pkg::L_OPEN: begin
				if (flag_q && lock_button) begin
					state_d = kcl_pkg::L_IDLE;
				end
			end
			default: begin
				state_d = kcl_pkg::L_IDLE;
			end
		endcase
		if (state_d == kcl_pkg::L_IDLE) begin
			pos_d  = '0;
			flag_d = 1'b0;
		end else if (state_d == kcl_pkg::L_OPEN) begin
			flag_d = 1'b1;
		end
		unlocked_next = flag_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kcl_pkg::L_IDLE;
			pos_q   <= '0;
			flag_q  <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			pos_q   <= pos_d;
			flag_q  <= flag_d;
		end
	end

endmodule

### design/kcl_change.sv
module kcl_change (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [7:0]                  key_code,
	input  logic                        lock_button,
	input  logic [kcl_pkg::WIN_W-1:0]   confirm_window,
	output kcl_pkg::code_t              code,
	output logic                        code_saved_next
);

	kcl_pkg::change_state_t       state_q, state_d;
	logic [kcl_pkg::CPOS_W-1:0]   pos_q, pos_d;
	logic [kcl_pkg::WIN_W-1:0]    win_q, win_d;
	logic [7:0]                   pending_q [kcl_pkg::NEW_CODE_KEYS];
	logic                         pend_we;
	logic [7:0]                   pending_rd;
	logic                         pos_in_range;
	kcl_pkg::code_store_t         store_q;
	logic [kcl_pkg::POS_W-1:0]    length_q;
	logic                         win_full;

	assign pos_in_range = (pos_q < kcl_pkg::CPOS_W'(kcl_pkg::NEW_CODE_KEYS));
	assign pending_rd   = pos_in_range ? pending_q[pos_q[kcl_pkg::PEND_IDX_W-1:0]]
	                                   : kcl_pkg::KEY_NONE;
	assign win_full     = (win_q == kcl_pkg::WINDOW_MAX);

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		win_d   = win_q;
		pend_we = 1'b0;
		unique case (state_q)
			kcl_pkg::C_IDLE: begin
				if (key_code == kcl_pkg::KEY_STAR && lock_button) begin
					state_d = kcl_pkg::C_START;
				end
			end
			kcl_pkg::C_START: begin
				if (key_code == kcl_pkg::KEY_NONE && !lock_button) begin
					state_d = kcl_pkg::C_WAIT_PRESS;
				end
			end
			kcl_pkg::C_WAIT_PRESS: begin
				if (key_code != kcl_pkg::KEY_NONE) begin
					state_d = kcl_pkg::C_WAIT_RELEASE;
					pend_we = pos_in_range;
					pos_d   = pos_q + kcl_pkg::CPOS_W'(1);
				end
			end
			kcl_pkg::C_WAIT_RELEASE: begin
				if (key_code == kcl_pkg::KEY_NONE) begin
					if (pos_in_range) begin
						state_d = kcl_pkg::C_WAIT_PRESS;
					end else begin
						state_d = kcl_pkg::C_REENTER;
						pos_d   = '0;
					end
				end
			end
			kcl_pkg::C_REENTER: begin
				if (key_code == kcl_pkg::KEY_NONE && win_q < confirm_window) begin
					win_d = win_full ? win_q : win_q + kcl_pkg::WIN_W'(1);
				end else if (key_code == pending_rd && win_q <= confirm_window) begin
					state_d = kcl_pkg::C_REL_AGAIN;
					win_d   = win_full ? win_q : win_q + kcl_pkg::WIN_W'(1);
					pos_d   = pos_q + kcl_pkg::CPOS_W'(1);
				end else begin
					state_d = kcl_pkg::C_IDLE;
				end
			end
			kcl_pkg::C_REL_AGAIN: begin
				if (key_code == kcl_pkg::KEY_NONE) begin
					if (win_q > confirm_window) begin
						// window passed after the re-entry: give up
						state_d = kcl_pkg::C_IDLE;
					end else if (pos_in_range) begin
						state_d = kcl_pkg::C_REENTER;
						win_d   = win_full ? win_q : win_q + kcl_pkg::WIN_W'(1);
					end else begin
						state_d = kcl_pkg::C_SAVE;
					end
				end else if (win_q < confirm_window) begin
					win_d = win_full ? win_q : win_q + kcl_pkg::WIN_W'(1);
				end
			end
			default: begin
				state_d = kcl_pkg::C_IDLE;
			end
		endcase
		if (state_d == kcl_pkg::C_IDLE) begin
			pos_d = '0;
			win_d = '0;
		end
		code_saved_next = step && (state_d == kcl_pkg::C_SAVE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= kcl_pkg::C_IDLE;
			pos_q    <= '0;
			win_q    <= '0;
			store_q  <= kcl_pkg::code_store_reset();
			length_q <= kcl_pkg::POS_W'(kcl_pkg::CODE_SLOTS);
		end else if (step) begin
			state_q <= state_d;
			pos_q   <= pos_d;
			win_q   <= win_d;
			if (state_d == kcl_pkg::C_SAVE) begin
				for (int i = 0; i < kcl_pkg::SAVE_KEYS; i++) begin
					store_q[i + 1] <= pending_q[i];
				end
				length_q <= kcl_pkg::POS_W'(kcl_pkg::SAVE_KEYS + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && pend_we) begin
			pending_q[pos_q[kcl_pkg::PEND_IDX_W-1:0]] <= key_code;
		end
	end

	assign code.store  = store_q;
	assign code.length = length_q;

endmodule

### design/keypad_combination_lock_core.sv
// a result passes through the input register and then the result register to the master side
// throughput: one item per cycle; the input register and the result register
// each pass an item on every cycle the downstream side takes one
// reset: arst_n clears all machines, restores the code '#12345' and sets the
// confirm window to 10; the new-code entry buffer holds no defined value
module keypad_combination_lock_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // key_code[7:0], lock_button[8], change_step[9], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // unlocked[0], code_saved[1], zero
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata
);

	logic                       valid_s1;
	logic [7:0]                 key_s1;
	logic                       lb_s1;
	logic                       cs_s1;
	logic                       m_valid_q;
	logic                       unlocked_q;
	logic                       saved_q;
	logic [kcl_pkg::WIN_W-1:0]  window_q;
	logic                       adv;
	logic [7:0]                 held_key_next;
	logic                       unlocked_next;
	logic                       saved_next;
	kcl_pkg::code_t             code;

	// item in the input register moves on when the result register is empty or its item is taken
	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= kcl_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_s1 <= s_tdata[7:0];
			lb_s1  <= s_tdata[8];
			cs_s1  <= s_tdata[9];
		end
	end

	kcl_qual u_qual (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.key_code      (key_s1),
		.held_key_next (held_key_next)
	);

	kcl_lock u_lock (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.held_key      (held_key_next),
		.lock_button   (lb_s1),
		.code          (code),
		.unlocked_next (unlocked_next)
	);

	kcl_change u_change (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (adv && cs_s1),
		.key_code        (key_s1),
		.lock_button     (lb_s1),
		.confirm_window  (window_q),
		.code            (code),
		.code_saved_next (saved_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unlocked_q <= unlocked_next;
			saved_q    <= saved_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, saved_q, unlocked_q};

endmodule

### sim/keypad_combination_lock_core_test.sv
module keypad_combination_lock_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES          = 6;
	localparam int PHASE_TICKS     = 300;
	localparam int QUIET_LIMIT     = 3000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam logic [8*16-1:0] KEYPAD = "0123456789ABCD#*";

	typedef struct packed {
		logic [7:0] key;
		logic       lb;
		logic       cs;
		logic       typed;
		logic [1:0] res;    // {code_saved, unlocked}
	} tick_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [15:0] s_tdata = '0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_wdata = '0;

	keypad_combination_lock_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// predicted lock state
	kcl_pkg::qual_state_t   q_st;
	logic [7:0]             held;
	kcl_pkg::lock_state_t   l_st;
	int unsigned            l_pos;
	logic                   is_open;
	logic [7:0]             code [kcl_pkg::CODE_SLOTS];
	int unsigned            code_len;
	kcl_pkg::change_state_t c_st;
	int unsigned            c_pos;
	logic [7:0]             new_code [kcl_pkg::NEW_CODE_KEYS];
	int unsigned            win_cnt;
	logic [3:0]             win_limit;

	logic [1:0] outputs_due [$];
	logic [1:0] due;
	int         errors = 0;
	int         items_sent = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_asks = 0;
	int         hold_done = 0;
	int         hold_left = 0;
	int         quiet_cycles = 0;

	tick_row_t opening [25] = '{
		'{8'h00, 1'b0, 1'b0, 1'b1, 2'b00},
		'{8'hFF, 1'b1, 1'b1, 1'b1, 2'b00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
		'{8'h80, 1'b0, 1'b1, 1'b0, 2'b00},
		'{8'h00, 1'b1, 1'b0, 1'b0, 2'b00},
		'{"#",   1'b0, 1'b0, 1'b0, 2'b00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
		'{"1",   1'b0, 1'b0, 1'b0, 2'b00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
		'{"2",   1'b0, 1'b0, 1'b0, 2'b00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
		'{"3",   1'b0, 1'b0, 1'b0, 2'b00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
		'{"4",   1'b0, 1'b0, 1'b0, 2'b00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
		'{"5",   1'b0, 1'b0, 1'b0, 2'b00},
		'{8'h00, 1'b0, 1'b0, 1'b1, 2'b01},
		'{8'h00, 1'b1, 1'b1, 1'b1, 2'b00},
		// second key cuts in while the first is held
		'{"#",   1'b0, 1'b0, 1'b0, 2'b00},
		'{"1",   1'b0, 1'b0, 1'b0, 2'b00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
		'{"*",   1'b1, 1'b1, 1'b0, 2'b00},
		'{8'h00, 1'b0, 1'b1, 1'b0, 2'b00},
		'{"7",   1'b0, 1'b1, 1'b0, 2'b00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 2'b00}
	};

	function automatic logic [7:0] code_at(input int unsigned i);
		return (i < kcl_pkg::CODE_SLOTS) ? code[i] : kcl_pkg::KEY_NONE;
	endfunction

	function automatic logic [7:0] new_code_at(input int unsigned i);
		return (i < kcl_pkg::NEW_CODE_KEYS) ? new_code[i] : kcl_pkg::KEY_NONE;
	endfunction

	function automatic void bump_window();
		if (win_cnt < int'(kcl_pkg::WINDOW_MAX)) win_cnt++;
	endfunction

	// one tick of the qualifier and the lock, and of the change machine when cs is set, returns {code_saved, unlocked}
	function automatic logic [1:0] advance_lock(input logic [7:0] key, input logic lb,
			input logic cs);
		logic saved;
		saved = 1'b0;

		case (q_st)
			kcl_pkg::Q_IDLE:
				q_st = (key != kcl_pkg::KEY_NONE) ? kcl_pkg::Q_PRESSED : kcl_pkg::Q_IDLE;
			kcl_pkg::Q_PRESSED: begin
				if (key == kcl_pkg::KEY_NONE) q_st = kcl_pkg::Q_IDLE;
				else if (key != held) q_st = kcl_pkg::Q_WAIT;
			end
			kcl_pkg::Q_WAIT: if (key == kcl_pkg::KEY_NONE) q_st = kcl_pkg::Q_IDLE;
			default: q_st = kcl_pkg::Q_IDLE;
		endcase
		held = (q_st == kcl_pkg::Q_PRESSED) ? key : kcl_pkg::KEY_NONE;

		case (l_st)
			kcl_pkg::L_IDLE: begin
				l_pos = 0;
				if (held == code_at(0)) begin
					l_st = kcl_pkg::L_START;
					l_pos = 1;
				end
			end
			kcl_pkg::L_START: begin
				if (held == code_at(0)) l_st = kcl_pkg::L_START;
				else if (held == kcl_pkg::KEY_NONE) l_st = kcl_pkg::L_WAIT;
				else l_st = kcl_pkg::L_IDLE;
			end
			kcl_pkg::L_WAIT: begin
				if (held == code_at(l_pos)) begin
					l_st = kcl_pkg::L_PRESSED;
					l_pos++;
				end else if (held != kcl_pkg::KEY_NONE) begin
					l_st = kcl_pkg::L_IDLE;
				end
			end
			kcl_pkg::L_PRESSED: begin
				if (held == kcl_pkg::KEY_NONE && l_pos >= code_len) l_st = kcl_pkg::L_OPEN;
				else if (held == kcl_pkg::KEY_NONE) l_st = kcl_pkg::L_WAIT;
				else if (l_pos == 0 || held != code_at(l_pos - 1)) l_st = kcl_pkg::L_IDLE;
			end
			kcl_pkg::L_OPEN: if (is_open && lb) l_st = kcl_pkg::L_IDLE;
			default: l_st = kcl_pkg::L_IDLE;
		endcase
		if (l_st == kcl_pkg::L_IDLE) begin
			l_pos = 0;
			is_open = 1'b0;
		end else if (l_st == kcl_pkg::L_OPEN) begin
			is_open = 1'b1;
		end

		if (cs) begin
			case (c_st)
				kcl_pkg::C_IDLE:
					if (key == kcl_pkg::KEY_STAR && lb) c_st = kcl_pkg::C_START;
				kcl_pkg::C_START:
					if (key == kcl_pkg::KEY_NONE && !lb) c_st = kcl_pkg::C_WAIT_PRESS;
				kcl_pkg::C_WAIT_PRESS: begin
					if (key != kcl_pkg::KEY_NONE) begin
						c_st = kcl_pkg::C_WAIT_RELEASE;
						if (c_pos < kcl_pkg::NEW_CODE_KEYS) new_code[c_pos] = key;
						c_pos++;
					end
				end
				kcl_pkg::C_WAIT_RELEASE: begin
					if (key == kcl_pkg::KEY_NONE) begin
						if (c_pos < kcl_pkg::NEW_CODE_KEYS) begin
							c_st = kcl_pkg::C_WAIT_PRESS;
						end else begin
							c_st = kcl_pkg::C_REENTER;
							c_pos = 0;
						end
					end
				end
				kcl_pkg::C_REENTER: begin
					if (key == kcl_pkg::KEY_NONE && win_cnt < int'(win_limit)) begin
						bump_window();
					end else if (key == new_code_at(c_pos) && win_cnt <= int'(win_limit)) begin
						c_st = kcl_pkg::C_REL_AGAIN;
						bump_window();
						c_pos++;
					end else begin
						c_st = kcl_pkg::C_IDLE;
					end
				end
				kcl_pkg::C_REL_AGAIN: begin
					if (key == kcl_pkg::KEY_NONE) begin
						// window used up after a re-entered key goes back to idle
						if (win_cnt > int'(win_limit)) c_st = kcl_pkg::C_IDLE;
						else if (c_pos < kcl_pkg::NEW_CODE_KEYS) begin
							c_st = kcl_pkg::C_REENTER;
							bump_window();
						end else begin
							c_st = kcl_pkg::C_SAVE;
						end
					end else if (win_cnt < int'(win_limit)) begin
						bump_window();
					end
				end
				default: c_st = kcl_pkg::C_IDLE;
			endcase
			if (c_st == kcl_pkg::C_IDLE) begin
				c_pos = 0;
				win_cnt = 0;
			end else if (c_st == kcl_pkg::C_SAVE) begin
				for (int i = 0; i < kcl_pkg::SAVE_KEYS; i++) code[i + 1] = new_code[i];
				code_len = kcl_pkg::SAVE_KEYS + 1;
				saved = 1'b1;
			end
		end
		return {saved, is_open};
	endfunction

	function automatic logic [7:0] keypad_key();
		int unsigned pick;
		pick = $urandom_range(15);
		return KEYPAD[8*pick +: 8];
	endfunction

	task automatic send_tick(input logic [7:0] key, input logic lb, input logic cs,
			input logic typed, input logic [1:0] typed_res);
		logic [1:0] res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, cs, lb, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = advance_lock(key, lb, cs);
		outputs_due.push_back(typed ? typed_res : res);
		items_sent++;
	endtask

	task automatic press(input logic [7:0] key, input logic lb, input int hold, input int gap,
			input int cs_pct);
		repeat (hold) send_tick(key, lb, $urandom_range(99) < cs_pct, 1'b0, 2'b00);
		repeat (gap)
			send_tick(kcl_pkg::KEY_NONE, 1'b0, $urandom_range(99) < cs_pct, 1'b0, 2'b00);
	endtask

	// mostly the current code, now and then a wrong key or a key cutting in
	task automatic type_code();
		int unsigned n;
		logic [7:0] k;
		n = code_len;
		for (int i = 0; i < n; i++) begin
			k = code[i];
			if ($urandom_range(99) < 8) k = keypad_key();
			press(k, 1'b0, $urandom_range(1, 3),
				($urandom_range(99) < 10) ? 0 : $urandom_range(1, 2), 30);
		end
		if ($urandom_range(99) < 60)
			press(kcl_pkg::KEY_NONE, 1'b1, $urandom_range(1, 2), $urandom_range(0, 1), 30);
	endtask

	task automatic enter_new_code();
		logic [7:0] keys [kcl_pkg::NEW_CODE_KEYS];
		int cs_pct;
		int hold_max;
		int pick;
		cs_pct = $urandom_range(1) ? 100 : 85;
		pick = $urandom_range(99);
		hold_max = (pick < 40) ? 1 : (pick < 80) ? 2 : 10;
		foreach (keys[i]) keys[i] = keypad_key();
		press(kcl_pkg::KEY_STAR, 1'b1, $urandom_range(1, 2), $urandom_range(1, 2), cs_pct);
		foreach (keys[i])
			press(keys[i], 1'b0, $urandom_range(1, 2), $urandom_range(1, 2), cs_pct);
		// re-entry, long holds run the confirm window out
		foreach (keys[i])
			press(($urandom_range(99) < 5) ? keypad_key() : keys[i], 1'b0,
				$urandom_range(1, hold_max), $urandom_range(1, hold_max), cs_pct);
	endtask

	task automatic noise();
		repeat ($urandom_range(1, 4))
			send_tick(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'b0, 2'b00);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (outputs_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_window(input logic [3:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_limit = value;
	endtask

	// result side: random stalls, one long hold-off on request, checking
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (outputs_due.size() == 0) begin
				$error("unexpected result transfer, m_tdata %h", m_tdata);
				errors++;
			end else begin
				due = outputs_due.pop_front();
				if (m_tdata[0] !== due[0]) begin
					$error("unlocked: expected %0b, got %0b", due[0], m_tdata[0]);
					errors++;
				end
				if (m_tdata[1] !== due[1]) begin
					$error("code_saved: expected %0b, got %0b", due[1], m_tdata[1]);
					errors++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_done != hold_asks) begin
			hold_done = hold_asks;
			hold_left = HOLD_OFF_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int send_idle [PHASES];
		int recv_stall [PHASES];
		int stop_at;
		int pick;

		send_idle  = '{0, 87, 0, 19, 0, 19};
		recv_stall = '{0, 0, 87, 19, 0, 19};

		q_st = kcl_pkg::Q_IDLE;
		held = kcl_pkg::KEY_NONE;
		l_st = kcl_pkg::L_IDLE;
		l_pos = 0;
		is_open = 1'b0;
		code[0] = kcl_pkg::KEY_HASH;
		for (int k = 1; k < kcl_pkg::CODE_SLOTS; k++) code[k] = kcl_pkg::KEY_DIGIT_ZERO + 8'(k);
		code_len = kcl_pkg::CODE_SLOTS;
		c_st = kcl_pkg::C_IDLE;
		c_pos = 0;
		foreach (new_code[i]) new_code[i] = kcl_pkg::KEY_NONE;
		win_cnt = 0;
		win_limit = kcl_pkg::WINDOW_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			send_tick(opening[i].key, opening[i].lb, opening[i].cs, opening[i].typed,
				opening[i].res);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain_results();
				case (p)
					1: write_window(kcl_pkg::WINDOW_MAX);
					2: write_window(4'd0);
					3: write_window(4'($urandom_range(1, 14)));
					4: write_window(4'd3);
					default: write_window(4'($urandom_range(15)));
				endcase
			end
			send_idle_pct = send_idle[p];
			recv_stall_pct = recv_stall[p];
			// receiver holds off while items keep coming, so the input backs up
			if (p == 4) hold_asks++;
			stop_at = items_sent + PHASE_TICKS;
			while (items_sent < stop_at) begin
				pick = $urandom_range(99);
				if (pick < 40) type_code();
				else if (pick < 75) enter_new_code();
				else noise();
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (errors == 0 && outputs_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
